// File: src/aek_pkg.sv
// Shared types, constants and the sequence decode function of the ANSI key decoder.
`timescale 1ns / 1ps

package aek_pkg;

    // Sequence buffer depth and the width of the count that tracks it.
    localparam int SEQ_DEPTH = 16;
    localparam int CNT_W     = $clog2(SEQ_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_NONE  = CNT_W'(0);
    localparam logic [CNT_W-1:0] CNT_ESC   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_OPEN  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_DEPTH = CNT_W'(SEQ_DEPTH);

    // Key queue between the front and back parts; depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] ESC_WAIT_RESET = 16'd60;

    // Action codes of an input word.
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Character codes.
    localparam logic [7:0] CH_NUL  = 8'd0;
    localparam logic [7:0] CH_BS   = 8'd8;
    localparam logic [7:0] CH_LF   = 8'd10;
    localparam logic [7:0] CH_CR   = 8'd13;
    localparam logic [7:0] CH_ESC  = 8'd27;
    localparam logic [7:0] CH_DEL  = 8'd127;
    localparam logic [7:0] CH_0    = 8'h30;
    localparam logic [7:0] CH_9    = 8'h39;
    localparam logic [7:0] CH_CSI  = 8'h5B;
    localparam logic [7:0] CH_SS3  = 8'h4F;
    localparam logic [7:0] CH_TILDE = 8'h7E;
    localparam logic [7:0] FIN_LO  = 8'h40;
    localparam logic [7:0] FIN_HI  = 8'h7E;
    localparam logic [7:0] CH_A = 8'h41;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_F = 8'h46;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_K = 8'h4B;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_S = 8'h53;

    // Key codes.
    localparam logic [8:0] K_NONE  = 9'd0;
    localparam logic [8:0] K_ESC   = 9'd256;
    localparam logic [8:0] K_UP    = 9'd257;
    localparam logic [8:0] K_DOWN  = 9'd258;
    localparam logic [8:0] K_RIGHT = 9'd259;
    localparam logic [8:0] K_LEFT  = 9'd260;
    localparam logic [8:0] K_HOME  = 9'd261;
    localparam logic [8:0] K_END   = 9'd262;
    localparam logic [8:0] K_INS   = 9'd263;
    localparam logic [8:0] K_DEL   = 9'd264;
    localparam logic [8:0] K_PGUP  = 9'd265;
    localparam logic [8:0] K_PGDN  = 9'd266;
    localparam logic [8:0] K_F1    = 9'd267;
    localparam logic [8:0] K_F6    = 9'd272;
    localparam logic [8:0] K_F11   = 9'd277;
    localparam logic [8:0] K_F12   = 9'd278;

    typedef struct packed {
        logic        action;
        logic [7:0]  data_byte;
        logic [31:0] now_ms;
    } t_in_word;

    typedef struct packed {
        logic [8:0] key_code;
        logic       is_last;
    } t_out_word;

    // One queue entry: the one or two keys that an input word produced.
    typedef struct packed {
        logic       two;
        logic [8:0] key0;
        logic [8:0] key1;
    } t_key_pair;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_stat;

    // Key of a finished sequence, or K_NONE when it means nothing.
    function automatic logic [8:0] aek_decode(input logic       is_ss3,
                                              input logic [7:0] f,
                                              input logic [7:0] num);
        logic [8:0] k;
        k = K_NONE;
        case (f)
            CH_A:    k = K_UP;
            CH_B:    k = K_DOWN;
            CH_C:    k = K_RIGHT;
            CH_D:    k = K_LEFT;
            CH_H:    k = K_HOME;
            CH_F:    k = K_END;
            default: k = K_NONE;
        endcase
        if (k == K_NONE) begin
            if (is_ss3) begin
                if (f >= CH_P && f <= CH_S) begin
                    k = K_F1 + {1'b0, f - CH_P};
                end
            end else if (f == CH_K) begin
                k = K_END;
            end else if (f == CH_TILDE) begin
                case (num)
                    8'd1, 8'd7:  k = K_HOME;
                    8'd2:        k = K_INS;
                    8'd3:        k = K_DEL;
                    8'd4, 8'd8:  k = K_END;
                    8'd5:        k = K_PGUP;
                    8'd6:        k = K_PGDN;
                    8'd11, 8'd12, 8'd13, 8'd14, 8'd15:
                        k = K_F1 + {1'b0, num - 8'd11};
                    8'd17, 8'd18, 8'd19, 8'd20, 8'd21:
                        k = K_F6 + {1'b0, num - 8'd17};
                    8'd23:       k = K_F11;
                    8'd24:       k = K_F12;
                    default:     k = K_NONE;
                endcase
            end
        end
        return k;
    endfunction

endpackage

// File: src/aek_fifo.sv
// Short key queue that decouples the parser from the output stage.
`timescale 1ns / 1ps

module aek_fifo
    import aek_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_key_pair   i_push_data,
    input  logic        i_pop,
    output t_key_pair   o_head,
    output t_queue_stat o_stat
);

    t_key_pair             r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr_ptr;
    logic [QUEUE_AW-1:0]   r_rd_ptr;
    logic [QUEUE_CW-1:0]   r_count;
    logic                  w_push;
    logic                  w_pop;

    assign o_stat.full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign w_push       = i_push && !o_stat.full;
    assign w_pop        = i_pop && !o_stat.empty;
    assign o_head       = r_mem[r_rd_ptr];

    // Storage for queued words.
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("key queue fill level beyond its depth");

endmodule

// File: src/aek_front.sv
// Front part: accepts input words, runs the escape sequence parser and queues keys.
`timescale 1ns / 1ps

module aek_front
    import aek_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    input  t_queue_stat i_q_stat,
    output logic        o_push,
    output t_key_pair   o_push_data
);

    logic [15:0]      r_esc_wait;
    logic [CNT_W-1:0] r_seq_count, n_seq_count;
    logic             r_seq_is_ss3, n_seq_is_ss3;
    logic [7:0]       r_seq_number, n_seq_number;
    logic             r_digits_open, n_digits_open;
    logic [7:0]       r_last, n_last;
    logic             r_after_cr, n_after_cr;
    logic [31:0]      r_esc_started, n_esc_started;

    logic             w_accept;
    logic [7:0]       w_c;
    logic [31:0]      w_elapsed;
    logic             w_storing;
    logic             w_is_digit;
    logic [11:0]      w_digit_sum;
    logic [7:0]       w_num_next;
    logic [7:0]       w_final;
    logic [8:0]       w_seq_key;
    logic [7:0]       w_byte;
    logic             w_handled;
    logic [1:0]       w_nkeys;
    logic [8:0]       w_key0;
    logic [8:0]       w_key1;

    assign o_in_stall  = i_q_stat.full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_c         = i_in_data.data_byte;
    assign w_elapsed   = i_in_data.now_ms - r_esc_started;

    // Decimal number and final byte of an open sequence.
    assign w_storing   = (r_seq_count < CNT_DEPTH);
    assign w_is_digit  = r_digits_open && (w_c >= CH_0) && (w_c <= CH_9);
    assign w_digit_sum = ({4'd0, r_seq_number} * 12'd10) + {4'd0, w_c - CH_0};
    assign w_num_next  = (w_storing && w_is_digit)
                       ? ((w_digit_sum > 12'd255) ? 8'd255 : w_digit_sum[7:0])
                       : r_seq_number;
    assign w_final     = w_storing ? w_c : r_last;
    assign w_seq_key   = aek_decode(r_seq_is_ss3, w_final, w_num_next);

    // Translated plain byte.
    assign w_byte = (w_c == CH_LF) ? CH_CR : ((w_c == CH_DEL) ? CH_BS : w_c);

    // Parser next state and the keys this word produces.
    always_comb begin
        n_seq_count   = r_seq_count;
        n_seq_is_ss3  = r_seq_is_ss3;
        n_seq_number  = r_seq_number;
        n_digits_open = r_digits_open;
        n_last        = r_last;
        n_after_cr    = r_after_cr;
        n_esc_started = r_esc_started;
        w_handled     = 1'b0;
        w_nkeys       = 2'd0;
        w_key0        = K_NONE;
        w_key1        = K_NONE;
        if (i_in_data.action == ACT_TICK) begin
            if (r_seq_count == CNT_ESC && w_elapsed >= {16'd0, r_esc_wait}) begin
                n_seq_count = CNT_NONE;
                w_key0      = K_ESC;
                w_nkeys     = 2'd1;
            end
        end else begin
            if (r_seq_count == CNT_ESC) begin
                if (w_c == CH_CSI || w_c == CH_SS3) begin
                    n_seq_count   = CNT_OPEN;
                    n_seq_is_ss3  = (w_c == CH_SS3);
                    n_seq_number  = 8'd0;
                    n_digits_open = 1'b1;
                    n_last        = w_c;
                    w_handled     = 1'b1;
                end else begin
                    // Escape on its own, then the byte is handled as usual.
                    n_seq_count = CNT_NONE;
                    w_key0      = K_ESC;
                    w_nkeys     = 2'd1;
                end
            end else if (r_seq_count >= CNT_OPEN) begin
                if (w_storing) begin
                    n_seq_count  = r_seq_count + 1'b1;
                    n_last       = w_c;
                    n_seq_number = w_num_next;
                    if (!w_is_digit) begin
                        n_digits_open = 1'b0;
                    end
                end
                if (r_seq_is_ss3 || (w_c >= FIN_LO && w_c <= FIN_HI)) begin
                    n_seq_count = CNT_NONE;
                    if (w_seq_key != K_NONE) begin
                        w_key0  = w_seq_key;
                        w_nkeys = 2'd1;
                    end
                end
                w_handled = 1'b1;
            end
            if (!w_handled) begin
                if (w_c == CH_ESC) begin
                    n_seq_count   = CNT_ESC;
                    n_esc_started = i_in_data.now_ms;
                    n_after_cr    = 1'b0;
                end else if (r_after_cr && (w_c == CH_LF || w_c == CH_NUL)) begin
                    n_after_cr = 1'b0;
                end else begin
                    n_after_cr = (w_c == CH_CR);
                    if (w_nkeys == 2'd0) begin
                        w_key0  = {1'b0, w_byte};
                        w_nkeys = 2'd1;
                    end else begin
                        w_key1  = {1'b0, w_byte};
                        w_nkeys = 2'd2;
                    end
                end
            end
        end
    end

    assign o_push           = w_accept && (w_nkeys != 2'd0);
    assign o_push_data.two  = (w_nkeys == 2'd2);
    assign o_push_data.key0 = w_key0;
    assign o_push_data.key1 = w_key1;

    // Parser state and the wait register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc_wait    <= ESC_WAIT_RESET;
            r_seq_count   <= CNT_NONE;
            r_seq_is_ss3  <= 1'b0;
            r_seq_number  <= 8'd0;
            r_digits_open <= 1'b1;
            r_last        <= 8'd0;
            r_after_cr    <= 1'b0;
            r_esc_started <= 32'd0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_esc_wait <= i_cfg_data;
            end
            if (w_accept) begin
                r_seq_count   <= n_seq_count;
                r_seq_is_ss3  <= n_seq_is_ss3;
                r_seq_number  <= n_seq_number;
                r_digits_open <= n_digits_open;
                r_last        <= n_last;
                r_after_cr    <= n_after_cr;
                r_esc_started <= n_esc_started;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_seq_count <= CNT_DEPTH)
        else $error("sequence count beyond the buffer depth");

    a_esc_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_data.action == ACT_BYTE && r_seq_count == CNT_NONE
         && w_c == CH_ESC) |=> (r_seq_count == CNT_ESC))
        else $error("ESC with no sequence open did not start one");

    a_pair_starts_esc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_push_data.two) |-> (o_push_data.key0 == K_ESC))
        else $error("two keys from one word must begin with Escape");

endmodule

// File: src/aek_back.sv
// Back part: takes queued key pairs and delivers them one word at a time.
`timescale 1ns / 1ps

module aek_back
    import aek_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_key_pair   i_head,
    input  t_queue_stat i_q_stat,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_data
);

    logic       r_out_valid;
    t_out_word  r_out_data;
    logic       r_pend;
    logic [8:0] r_pend_key;
    logic       w_load;

    // The output register may take a new word when empty or being drained.
    assign w_load      = !r_out_valid || !i_out_stall;
    assign o_pop       = w_load && !r_pend && !i_q_stat.empty;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Control: output valid and the pending second key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (w_load) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (!i_q_stat.empty) begin
                r_out_valid <= 1'b1;
                r_pend      <= i_head.two;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload of the output word and the held second key.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (r_pend) begin
                r_out_data.key_code <= r_pend_key;
                r_out_data.is_last  <= 1'b1;
            end else begin
                r_out_data.key_code <= i_head.key0;
                r_out_data.is_last  <= !i_head.two;
                r_pend_key          <= i_head.key1;
            end
        end
    end

    a_pend_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> r_out_valid)
        else $error("second key pending without a first key on the output");

    a_pend_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> !r_out_data.is_last)
        else $error("first of two keys marked as last");

endmodule

// File: src/ansi_escape_key_decoder.sv
// ANSI escape key decoder top level: parser front, key queue and output stage.
// A key passes through the key queue and then the output register before it reaches the output.
// One input word per cycle while not stalled; a two-key word gives two output words.
// The input stalls only when the four-entry key queue is full.
// Synchronous active-low reset clears the parser, queue and output; wait register returns to 60.
`timescale 1ns / 1ps

module ansi_escape_key_decoder
    import aek_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_data
);

    logic        w_push;
    t_key_pair   w_push_data;
    logic        w_pop;
    t_key_pair   w_head;
    t_queue_stat w_q_stat;

    // Parser front end.
    aek_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_q_stat    (w_q_stat),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    // Key queue.
    aek_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_stat      (w_q_stat)
    );

    // Output stage.
    aek_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_stat    (w_q_stat),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// File: tb/tb.sv
// Self-checking testbench for the ANSI escape key decoder, with a key predictor and random handshakes.
`timescale 1ns / 1ps

module tb;
    import aek_pkg::*;

    // One row of the directed table; typed rows carry their expected keys.
    typedef struct packed {
        logic        act;
        logic [7:0]  byt;
        logic [31:0] at_ms;
        logic        typed;
        logic [1:0]  cnt;
        logic [8:0]  k0;
        logic [8:0]  k1;
    } t_row;

    localparam int DIR_ROWS = 27;
    localparam int PHASES   = 5;
    localparam int PHASE_BYTES = 190;
    localparam int DRAIN_LIMIT = 5000;
    localparam int TAIL_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_word    in_data = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_word   out_data;

    // Predictor state, mirroring what the decoder holds between words.
    logic [15:0] esc_wait = ESC_WAIT_RESET;
    int          open_len = 0;
    logic        open_ss3 = 1'b0;
    logic [7:0]  param_num = '0;
    logic        param_digits = 1'b1;
    logic [7:0]  final_byte = '0;
    logic        cr_pending = 1'b0;
    logic [31:0] esc_at = '0;

    // Keys produced by the word just predicted.
    logic [8:0]  step_keys [2];
    int          step_n = 0;

    t_out_word   due_keys [$];
    t_out_word   want;
    int          mismatches = 0;
    int          byte_items = 0;
    logic [31:0] clk_ms = '0;
    bit          in_calm = 1'b0;
    bit          out_calm = 1'b0;
    int          stall_left = 0;
    t_row        dir_rows [DIR_ROWS];

    ansi_escape_key_decoder dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic note_mismatch(input string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function automatic void add_key(input logic [8:0] k);
        step_keys[step_n] = k;
        step_n++;
    endfunction

    // Key named by a finished sequence, or K_NONE when it names nothing.
    function automatic logic [8:0] sequence_key();
        logic [8:0] k;
        case (final_byte)
            CH_A:    k = K_UP;
            CH_B:    k = K_DOWN;
            CH_C:    k = K_RIGHT;
            CH_D:    k = K_LEFT;
            CH_H:    k = K_HOME;
            CH_F:    k = K_END;
            default: k = K_NONE;
        endcase
        if (k != K_NONE) begin
            return k;
        end
        if (open_ss3) begin
            return (final_byte >= CH_P && final_byte <= CH_S) ?
                K_F1 + 9'(final_byte - CH_P) : K_NONE;
        end
        if (final_byte == CH_K) begin
            return K_END;
        end
        if (final_byte != CH_TILDE) begin
            return K_NONE;
        end
        // Tilde sequences: the number selects an editing or function key.
        if (param_num >= 8'd11 && param_num <= 8'd15) begin
            return K_F1 + 9'(param_num - 8'd11);
        end
        if (param_num >= 8'd17 && param_num <= 8'd21) begin
            return K_F6 + 9'(param_num - 8'd17);
        end
        case (param_num)
            8'd1, 8'd7: return K_HOME;
            8'd2:       return K_INS;
            8'd3:       return K_DEL;
            8'd4, 8'd8: return K_END;
            8'd5:       return K_PGUP;
            8'd6:       return K_PGDN;
            8'd23:      return K_F11;
            8'd24:      return K_F12;
            default:    return K_NONE;
        endcase
    endfunction

    // Advances the predictor by one input word and leaves its keys in step_keys.
    function automatic void predict_keys(input t_in_word w);
        logic [7:0]  c;
        logic [31:0] held_ms;
        logic [8:0]  k;
        int          v;
        bit          taken;
        step_n = 0;
        c = w.data_byte;
        if (w.action == ACT_TICK) begin
            held_ms = w.now_ms - esc_at;
            if (open_len == 1 && held_ms >= {16'd0, esc_wait}) begin
                open_len = 0;
                add_key(K_ESC);
            end
            return;
        end
        taken = 1'b0;
        if (open_len == 1) begin
            if (c == CH_CSI || c == CH_SS3) begin
                open_len = 2;
                open_ss3 = (c == CH_SS3);
                param_num = '0;
                param_digits = 1'b1;
                final_byte = c;
                taken = 1'b1;
            end else begin
                open_len = 0;
                add_key(K_ESC);
            end
        end else if (open_len >= 2) begin
            // Bytes beyond the buffer depth are not stored but may still end it.
            if (open_len < SEQ_DEPTH) begin
                open_len++;
                final_byte = c;
                if (param_digits && c >= CH_0 && c <= CH_9) begin
                    v = int'(param_num) * 10 + (int'(c) - int'(CH_0));
                    param_num = (v > 255) ? 8'd255 : 8'(v);
                end else begin
                    param_digits = 1'b0;
                end
            end
            if (open_ss3 || (c >= FIN_LO && c <= FIN_HI)) begin
                k = sequence_key();
                if (k != K_NONE) begin
                    add_key(k);
                end
                open_len = 0;
            end
            taken = 1'b1;
        end
        if (!taken) begin
            if (c == CH_ESC) begin
                open_len = 1;
                esc_at = w.now_ms;
                cr_pending = 1'b0;
            end else if (cr_pending && (c == CH_LF || c == CH_NUL)) begin
                cr_pending = 1'b0;
            end else begin
                cr_pending = (c == CH_CR);
                if (c == CH_LF) begin
                    c = CH_CR;
                end else if (c == CH_DEL) begin
                    c = CH_BS;
                end
                add_key({1'b0, c});
            end
        end
    endfunction

    function automatic int in_gap();
        if ($urandom_range(0, 29) == 0) begin
            in_calm = !in_calm;
        end
        return in_calm ? 0 : $urandom_range(0, 12);
    endfunction

    // Offers one word, waits for it to be taken, then queues its expected keys.
    task automatic drive_word(input t_in_word w, input logic typed, input int tn,
                              input logic [8:0] tk0, input logic [8:0] tk1);
        int gap;
        int i;
        gap = in_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        predict_keys(w);
        if (typed) begin
            step_n = tn;
            step_keys[0] = tk0;
            step_keys[1] = tk1;
        end
        for (i = 0; i < step_n; i++) begin
            due_keys.push_back('{key_code: step_keys[i], is_last: 1'(i == step_n - 1)});
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        t_in_word w;
        clk_ms = clk_ms + $urandom_range(0, 3);
        w.action = ACT_BYTE;
        w.data_byte = b;
        w.now_ms = clk_ms;
        drive_word(w, 1'b0, 0, K_NONE, K_NONE);
        byte_items++;
    endtask

    task automatic send_tick(input logic [31:0] t);
        t_in_word w;
        clk_ms = t;
        w.action = ACT_TICK;
        w.data_byte = 8'($urandom_range(0, 255));
        w.now_ms = t;
        drive_word(w, 1'b0, 0, K_NONE, K_NONE);
    endtask

    task automatic send_number(input int v);
        if (v >= 100) begin
            send_byte(8'(int'(CH_0) + v / 100));
        end
        if (v >= 10) begin
            send_byte(8'(int'(CH_0) + (v / 10) % 10));
        end
        send_byte(8'(int'(CH_0) + v % 10));
    endtask

    function automatic logic [7:0] pick_letter();
        case ($urandom_range(0, 10))
            0:       return CH_A;
            1:       return CH_B;
            2:       return CH_C;
            3:       return CH_D;
            4:       return CH_F;
            5:       return CH_H;
            6:       return CH_K;
            7:       return CH_P;
            8:       return 8'h51;
            9:       return 8'h52;
            default: return CH_S;
        endcase
    endfunction

    // ESC [ with an optional number, modifier and extra byte, ended by a tilde, a letter or another final byte.
    task automatic send_csi();
        int pick;
        send_byte(CH_ESC);
        send_byte(CH_CSI);
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            case ($urandom_range(0, 9))
                0:       send_number($urandom_range(1, 8));
                1, 2:    send_number($urandom_range(11, 15));
                3, 4:    send_number($urandom_range(17, 21));
                5:       send_number($urandom_range(23, 24));
                6:       send_number($urandom_range(9, 26));
                default: send_number($urandom_range(1, 24));
            endcase
        end else if (pick < 8) begin
            send_number($urandom_range(0, 999));
        end
        if ($urandom_range(0, 4) == 0) begin
            send_byte(8'h3B);
            send_number($urandom_range(1, 8));
        end
        if ($urandom_range(0, 9) == 0) begin
            send_byte(8'($urandom_range(8'h20, 8'h3F)));
        end
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            send_byte(CH_TILDE);
        end else if (pick < 8) begin
            send_byte(pick_letter());
        end else begin
            send_byte(8'($urandom_range(FIN_LO, FIN_HI)));
        end
    endtask

    // A lone ESC followed by ticks placed around the point where it times out.
    task automatic send_lone_esc();
        logic [31:0] t0;
        int          k;
        int          ticks;
        send_byte(CH_ESC);
        t0 = clk_ms;
        ticks = $urandom_range(1, 3);
        for (k = 0; k < ticks; k++) begin
            case ($urandom_range(0, 3))
                0:       send_tick(t0 + esc_wait - 32'd1);
                1:       send_tick(t0 + esc_wait);
                2:       send_tick(t0 + $urandom_range(0, esc_wait));
                default: send_tick(t0 + esc_wait + $urandom_range(1, 500));
            endcase
        end
    endtask

    task automatic random_event();
        int sel;
        int k;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 20) begin
            case ($urandom_range(0, 5))
                0:       send_byte(CH_CR);
                1:       send_byte(CH_LF);
                2:       send_byte(CH_NUL);
                3:       send_byte(CH_DEL);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end else if (sel < 45) begin
            send_csi();
        end else if (sel < 60) begin
            send_byte(CH_ESC);
            send_byte(CH_SS3);
            send_byte(($urandom_range(0, 9) < 6) ? pick_letter() : 8'($urandom_range(0, 255)));
        end else if (sel < 68) begin
            // Long parameter lists, which can run past the sequence buffer.
            send_byte(CH_ESC);
            send_byte(CH_CSI);
            n = $urandom_range(10, 20);
            for (k = 0; k < n; k++) begin
                send_byte(8'($urandom_range(8'h30, 8'h3F)));
            end
            send_byte(($urandom_range(0, 1) == 0) ? CH_TILDE : pick_letter());
        end else if (sel < 80) begin
            send_lone_esc();
        end else if (sel < 88) begin
            send_byte(CH_ESC);
            send_byte(8'($urandom_range(0, 255)));
        end else if (sel < 94) begin
            n = $urandom_range(1, 4);
            for (k = 0; k < n; k++) begin
                send_byte(8'($urandom_range(0, 255)));
            end
        end else begin
            send_tick($urandom());
        end
    endtask

    task automatic write_wait(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        esc_wait = v;
    endtask

    // Lets every expected key arrive, then waits out TAIL_CYCLES for words still in flight.
    task automatic settle();
        int spins;
        t_out_word left;
        in_valid <= 1'b0;
        spins = 0;
        while (due_keys.size() != 0 && spins < DRAIN_LIMIT) begin
            @(posedge clk);
            spins++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
        while (due_keys.size() != 0) begin
            left = due_keys.pop_front();
            note_mismatch($sformatf("key %0d never arrived", left.key_code));
        end
    endtask

    // Result side: check each accepted word and draw the next stall.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (due_keys.size() == 0) begin
                    note_mismatch($sformatf("unexpected key %0d", out_data.key_code));
                end else begin
                    want = due_keys.pop_front();
                    if (out_data.key_code !== want.key_code) begin
                        note_mismatch($sformatf("key_code %0d, expected %0d",
                                                out_data.key_code, want.key_code));
                    end
                    if (out_data.is_last !== want.is_last) begin
                        note_mismatch($sformatf("is_last %0b, expected %0b on key %0d",
                                                out_data.is_last, want.is_last,
                                                want.key_code));
                    end
                end
                if ($urandom_range(0, 24) == 0) begin
                    out_calm = !out_calm;
                end
                stall_left = out_calm ? 0 : $urandom_range(0, 12);
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus: reset, directed table, then random phases at several wait settings.
    initial begin
        int       r;
        int       ph;
        int       goal;
        t_in_word w;
        dir_rows = '{
            '{ACT_BYTE, 8'h00,    32'h0,          1'b1, 2'd0 + 2'd1, 9'h000, K_NONE},
            '{ACT_BYTE, 8'hFF,    32'h0,          1'b1, 2'd1, 9'h0FF, K_NONE},
            '{ACT_BYTE, CH_DEL,   32'h0,          1'b1, 2'd1, {1'b0, CH_BS}, K_NONE},
            '{ACT_BYTE, CH_CR,    32'h0,          1'b1, 2'd1, {1'b0, CH_CR}, K_NONE},
            '{ACT_BYTE, CH_LF,    32'h0,          1'b1, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_LF,    32'h0,          1'b1, 2'd1, {1'b0, CH_CR}, K_NONE},
            '{ACT_TICK, 8'hA5,    32'h0,          1'b1, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_ESC,   32'hFFFF_FFF0,  1'b1, 2'd0, K_NONE, K_NONE},
            '{ACT_TICK, 8'h5A,    32'h0000_002B,  1'b1, 2'd0, K_NONE, K_NONE},
            '{ACT_TICK, 8'hFF,    32'h0000_002C,  1'b1, 2'd1, K_ESC, K_NONE},
            '{ACT_BYTE, CH_ESC,   32'h0,          1'b1, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_ESC,   32'h0,          1'b1, 2'd1, K_ESC, K_NONE},
            '{ACT_BYTE, CH_CSI,   32'h1,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, 8'h32,    32'h2,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_TILDE, 32'h3,          1'b1, 2'd1, K_INS, K_NONE},
            '{ACT_BYTE, CH_ESC,   32'h4,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_SS3,   32'h5,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_P,     32'h6,          1'b1, 2'd1, K_F1, K_NONE},
            '{ACT_BYTE, CH_ESC,   32'h7,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, 8'h71,    32'h8,          1'b1, 2'd2, K_ESC, 9'h071},
            '{ACT_BYTE, CH_ESC,   32'h9,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_CSI,   32'hA,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_9,     32'hB,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_9,     32'hC,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_9,     32'hD,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_ESC,   32'hE,          1'b0, 2'd0, K_NONE, K_NONE},
            '{ACT_BYTE, CH_TILDE, 32'hF,          1'b1, 2'd0, K_NONE, K_NONE}
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: extremes, line-ending rules, timeout wrap and overflowing numbers.
        for (r = 0; r < DIR_ROWS; r++) begin
            w.action = dir_rows[r].act;
            w.data_byte = dir_rows[r].byt;
            w.now_ms = dir_rows[r].at_ms;
            drive_word(w, dir_rows[r].typed, int'(dir_rows[r].cnt),
                       dir_rows[r].k0, dir_rows[r].k1);
        end
        clk_ms = $urandom();

        for (ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1:       write_wait(16'd0);
                    2:       write_wait(16'hFFFF);
                    3:       write_wait(16'd1);
                    default: write_wait(16'($urandom_range(2, 300)));
                endcase
            end
            goal = byte_items + PHASE_BYTES;
            while (byte_items < goal) begin
                random_event();
            end
        end
        settle();

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(5_000_000);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: filelist.f
src/aek_pkg.sv
src/aek_fifo.sv
src/aek_front.sv
src/aek_back.sv
src/ansi_escape_key_decoder.sv
tb/tb.sv
